// File: rtl/fba_pkg.sv
// shared types and constants for the fixed block allocator
package fba_pkg;

    localparam int FIELD_W    = 24;
    localparam int USE_W      = 9;
    localparam int SIZE_W     = 16;
    localparam int COUNT_W    = 9;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 16'd64;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UNIT_SIZE  = 1'b0,
        REG_UNIT_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_EXHAUSTED  = 2'd1,
        STAT_BAD_OFFSET = 2'd2
    } status_t;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] free_offset;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] unit_offset;
        logic [1:0]         status;
        logic [USE_W-1:0]   units_in_use;
    } out_item_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ALLOC_RD,
        S_DIV,
        S_CHECK,
        S_MAP_RD,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic latch_in;
        logic div_start;
        logic alloc_commit;
        logic free_commit;
        logic set_exhausted;
        logic set_bad;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cfg_wr;
        logic clear_done;
        logic kind_free;
        logic depth_zero;
        logic size_zero;
        logic div_busy;
        logic q_bad;
        logic map_bit;
        logic out_busy;
    } ctrl_status_t;

endpackage

// File: rtl/fixed_block_allocator.sv
// Fixed-size block allocator over a pool of MAX_UNITS equal units, one request at a time.
// An allocate item pops the most recently freed unit and returns its byte offset; a free
// item takes any offset inside a unit, divides it by unit_size and pushes the unit back if
// it is allocated. An allocate steps at most through the dispatch, stack read and result states;
// a free through dispatch, the one-bit-per-cycle divider, check, map read and result. After
// reset and after every register write a clearing pass rebuilds the free stack and clears
// the allocation map, during which no item is accepted. The next item is taken while a
// finished result still waits on the m_ side.
module fixed_block_allocator #(
    parameter int MAX_UNITS   = 256,
    parameter int OFFSET_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  fba_pkg::in_item_t              s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output fba_pkg::out_item_t             m_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_data
);

    fba_pkg::ctrl_cmd_t    cmd;
    fba_pkg::ctrl_status_t status;

    assign cfg_ready = 1'b1;

    fba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fba_datapath #(
        .MAX_UNITS   (MAX_UNITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_item    (s_item),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_item    (m_item),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: rtl/fba_ram.sv
// generic single write port ram with registered read
module fba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/fba_div.sv
// iterative restoring divider, one quotient bit per cycle
module fba_div #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  fits;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor};
        fits      = (rem_shift >= {1'b0, divisor});
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/fba_ctrl.sv
// controller state machine for the fixed block allocator
module fba_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fba_pkg::ctrl_status_t status,
    output fba_pkg::ctrl_cmd_t    cmd
);

    fba_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fba_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fba_pkg::S_CLEAR: begin
                if (status.clear_done) begin
                    state_next = fba_pkg::S_IDLE;
                end
            end
            fba_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = fba_pkg::S_DISPATCH;
                end
            end
            fba_pkg::S_DISPATCH: begin
                if (!status.kind_free) begin
                    state_next = status.depth_zero ? fba_pkg::S_RESULT : fba_pkg::S_ALLOC_RD;
                end else begin
                    state_next = status.size_zero ? fba_pkg::S_RESULT : fba_pkg::S_DIV;
                end
            end
            fba_pkg::S_ALLOC_RD: begin
                state_next = fba_pkg::S_RESULT;
            end
            fba_pkg::S_DIV: begin
                if (!status.div_busy) begin
                    state_next = fba_pkg::S_CHECK;
                end
            end
            fba_pkg::S_CHECK: begin
                state_next = status.q_bad ? fba_pkg::S_RESULT : fba_pkg::S_MAP_RD;
            end
            fba_pkg::S_MAP_RD: begin
                state_next = fba_pkg::S_RESULT;
            end
            fba_pkg::S_RESULT: begin
                if (!status.out_busy) begin
                    state_next = fba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fba_pkg::S_CLEAR;
            end
        endcase
        // any register write restarts the clearing pass
        if (status.cfg_wr) begin
            state_next = fba_pkg::S_CLEAR;
        end
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            fba_pkg::S_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            fba_pkg::S_IDLE: begin
                s_ready      = 1'b1;
                cmd.latch_in = s_valid;
            end
            fba_pkg::S_DISPATCH: begin
                if (!status.kind_free) begin
                    cmd.set_exhausted = status.depth_zero;
                end else begin
                    cmd.set_bad   = status.size_zero;
                    cmd.div_start = !status.size_zero;
                end
            end
            fba_pkg::S_ALLOC_RD: begin
                cmd.alloc_commit = 1'b1;
            end
            fba_pkg::S_DIV: begin
                cmd = '0;
            end
            fba_pkg::S_CHECK: begin
                cmd.set_bad = status.q_bad;
            end
            fba_pkg::S_MAP_RD: begin
                cmd.free_commit = status.map_bit;
                cmd.set_bad     = !status.map_bit;
            end
            fba_pkg::S_RESULT: begin
                cmd.load_out = !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/fba_datapath.sv
// datapath: config registers, free stack, allocation map, divider and result register
module fba_datapath #(
    parameter int MAX_UNITS   = 256,
    parameter int OFFSET_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [fba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fba_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  fba_pkg::in_item_t                   s_item,
    input  logic                                m_ready,
    output logic                                m_valid,
    output fba_pkg::out_item_t                  m_item,
    input  fba_pkg::ctrl_cmd_t                  cmd,
    output fba_pkg::ctrl_status_t               status
);

    localparam int IDX_W  = $clog2(MAX_UNITS);
    localparam int CNT_W  = $clog2(MAX_UNITS + 1);
    localparam int OFF_W  = OFFSET_BITS;
    localparam int CMP_W  = (OFF_W > CNT_W) ? OFF_W : CNT_W;
    localparam int SZ_W   = fba_pkg::SIZE_W;
    localparam int UC_W   = fba_pkg::COUNT_W;
    localparam int FLD_W  = fba_pkg::FIELD_W;
    localparam int USE_W  = fba_pkg::USE_W;
    localparam int PROD_W = IDX_W + SZ_W;

    logic [SZ_W-1:0]    unit_size_reg, unit_size_next;
    logic [UC_W-1:0]    unit_count_reg, unit_count_next;
    logic [IDX_W-1:0]   clr_idx_reg;
    logic [CNT_W-1:0]   depth_reg;
    logic [CNT_W-1:0]   in_use_reg;
    logic               kind_reg;
    logic [OFF_W-1:0]   off_reg;
    fba_pkg::status_t   status_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               m_valid_reg;
    fba_pkg::out_item_t m_item_reg;

    logic [CNT_W-1:0]   eff_count;
    logic [IDX_W-1:0]   init_val;
    logic [OFF_W-1:0]   quotient;
    logic               div_busy;
    logic [IDX_W-1:0]   q_idx;

    logic               stk_we;
    logic [IDX_W-1:0]   stk_waddr, stk_wdata, stk_raddr, stk_rdata;
    logic               map_we;
    logic [IDX_W-1:0]   map_waddr;
    logic               map_wdata, map_rdata;

    // unit count of zero acts as one, above the pool size as the pool size
    always_comb begin
        if (unit_count_reg == '0) begin
            eff_count = CNT_W'(1);
        end else if (unit_count_reg > MAX_UNITS) begin
            eff_count = CNT_W'(MAX_UNITS);
        end else begin
            eff_count = CNT_W'(unit_count_reg);
        end
    end

    assign init_val = IDX_W'(eff_count - CNT_W'(1) - CNT_W'(clr_idx_reg));
    assign q_idx    = IDX_W'(quotient);

    always_comb begin
        unit_size_next  = unit_size_reg;
        unit_count_next = unit_count_reg;
        if (cfg_valid) begin
            case (cfg_index)
                fba_pkg::REG_UNIT_SIZE:  unit_size_next  = cfg_data[SZ_W-1:0];
                fba_pkg::REG_UNIT_COUNT: unit_count_next = cfg_data[UC_W-1:0];
                default: begin
                    unit_size_next = unit_size_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_size_reg  <= fba_pkg::SIZE_RESET;
            unit_count_reg <= fba_pkg::COUNT_RESET;
            clr_idx_reg    <= '0;
            depth_reg      <= '0;
            in_use_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            unit_size_reg  <= unit_size_next;
            unit_count_reg <= unit_count_next;
            if (cfg_valid) begin
                clr_idx_reg <= '0;
            end else if (cmd.clear_step) begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (cmd.clear_step) begin
                depth_reg  <= eff_count;
                in_use_reg <= '0;
            end else if (cmd.alloc_commit) begin
                depth_reg  <= depth_reg - CNT_W'(1);
                in_use_reg <= in_use_reg + CNT_W'(1);
            end else if (cmd.free_commit) begin
                depth_reg <= depth_reg + CNT_W'(1);
                if (in_use_reg != '0) begin
                    in_use_reg <= in_use_reg - CNT_W'(1);
                end
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            kind_reg   <= s_item.kind;
            off_reg    <= OFF_W'(s_item.free_offset);
            status_reg <= fba_pkg::STAT_OK;
            prod_reg   <= '0;
        end else begin
            if (cmd.set_exhausted) begin
                status_reg <= fba_pkg::STAT_EXHAUSTED;
            end else if (cmd.set_bad) begin
                status_reg <= fba_pkg::STAT_BAD_OFFSET;
            end
            if (cmd.alloc_commit) begin
                prod_reg <= PROD_W'(stk_rdata) * PROD_W'(unit_size_reg);
            end
        end
        if (cmd.load_out) begin
            m_item_reg.unit_offset  <= FLD_W'(OFF_W'(prod_reg));
            m_item_reg.status       <= status_reg;
            m_item_reg.units_in_use <= USE_W'(in_use_reg);
        end
    end

    // free stack: top of stack sits at depth minus one
    always_comb begin
        stk_we    = cmd.clear_step || cmd.free_commit;
        stk_waddr = cmd.clear_step ? clr_idx_reg : IDX_W'(depth_reg);
        stk_wdata = cmd.clear_step ? init_val : q_idx;
        stk_raddr = IDX_W'(depth_reg - CNT_W'(1));
    end

    always_comb begin
        map_we    = cmd.clear_step || cmd.alloc_commit || cmd.free_commit;
        map_wdata = cmd.alloc_commit;
        if (cmd.clear_step) begin
            map_waddr = clr_idx_reg;
        end else if (cmd.alloc_commit) begin
            map_waddr = stk_rdata;
        end else begin
            map_waddr = q_idx;
        end
    end

    fba_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_UNITS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    fba_ram #(
        .WIDTH (1),
        .DEPTH (MAX_UNITS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (q_idx),
        .rdata (map_rdata)
    );

    fba_div #(
        .DIVIDEND_W (OFF_W),
        .DIVISOR_W  (SZ_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (off_reg),
        .divisor  (unit_size_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb begin
        status.cfg_wr     = cfg_valid;
        status.clear_done = (clr_idx_reg == IDX_W'(MAX_UNITS - 1));
        status.kind_free  = (kind_reg == fba_pkg::KIND_FREE);
        status.depth_zero = (depth_reg == '0);
        status.size_zero  = (unit_size_reg == '0);
        status.div_busy   = div_busy;
        status.q_bad      = (CMP_W'(quotient) >= CMP_W'(eff_count)) ||
                            (depth_reg >= CNT_W'(MAX_UNITS));
        status.map_bit    = map_rdata;
        status.out_busy   = m_valid_reg && !m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
